@@ rtl/abif_pkg.sv @@
// ----------------------------------------------------------------------------
// abif_pkg
// Shared types and constants for the array binary search tree block.
// ----------------------------------------------------------------------------
package abif_pkg;

    localparam int unsigned KEY_MAX = 999;
    localparam int unsigned POS_W   = 4;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned STS_W   = 3;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [STS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_NO_SLOT   = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_CLEARED   = 3'd5,
        ST_INVALID   = 3'd6
    } t_status;

    typedef struct packed {
        logic load;
        logic step;
        logic write;
        logic clr_init;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic             key_ok;
        logic             empty;
        logic             match;
        logic             past_next;
        logic             clr_last;
        logic [POS_W-1:0] pos;
    } t_sts;

endpackage

@@ rtl/abif_dp.sv @@
// ----------------------------------------------------------------------------
// abif_dp
// Slot store, walk index, key register and the per-level compare.
// ----------------------------------------------------------------------------
module abif_dp #(
    parameter int TREE_SLOTS = 15,
    parameter int KEY_BITS   = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KEY_BITS-1:0] i_key,
    input  abif_pkg::t_cmd      i_cmd,
    output abif_pkg::t_sts      o_sts
);

    localparam int IDX_W = $clog2(TREE_SLOTS);
    localparam int NXT_W = IDX_W + 2;

    logic [KEY_BITS-1:0] r_mem [TREE_SLOTS];
    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] r_rd;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    n_idx;
    logic [IDX_W-1:0]    n_addr;
    logic [NXT_W-1:0]    nxt;
    logic                wr_en;
    logic [KEY_BITS-1:0] wr_data;

    assign nxt = (NXT_W'(r_idx) << 1) + ((r_key > r_rd) ? NXT_W'(2) : NXT_W'(1));

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.load || i_cmd.clr_init) begin
            n_idx = '0;
        end else if (i_cmd.clr_step) begin
            n_idx = r_idx + IDX_W'(1);
        end else if (i_cmd.step) begin
            n_idx = nxt[IDX_W-1:0];
        end
    end

    assign n_addr  = (i_cmd.load || i_cmd.step) ? n_idx : r_idx;
    assign wr_en   = i_cmd.write || i_cmd.clr_step;
    assign wr_data = i_cmd.clr_step ? '0 : r_key;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx] <= wr_data;
        end
        r_rd <= r_mem[n_addr];
        if (i_cmd.load) begin
            r_key <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    assign o_sts.key_ok    = (i_key != '0) && (33'(i_key) <= 33'(abif_pkg::KEY_MAX));
    assign o_sts.empty     = (r_rd == '0);
    assign o_sts.match     = (r_rd == r_key);
    assign o_sts.past_next = (nxt >= NXT_W'(TREE_SLOTS));
    assign o_sts.clr_last  = (r_idx == IDX_W'(TREE_SLOTS - 1));
    assign o_sts.pos       = abif_pkg::POS_W'(r_idx);

endmodule

@@ rtl/abif_ctrl.sv @@
// ----------------------------------------------------------------------------
// abif_ctrl
// Operation sequencer: accepts items, steps the walk and the clear sweep,
// and holds the result register.
// ----------------------------------------------------------------------------
module abif_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [abif_pkg::OP_W-1:0]     i_opcode,
    output abif_pkg::t_cmd                o_cmd,
    input  abif_pkg::t_sts                i_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [abif_pkg::STS_W-1:0]    o_status,
    output logic [abif_pkg::POS_W-1:0]    o_position
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_RESULT
    } t_state;

    t_state                       r_state;
    t_state                       n_state;
    logic                         r_report;
    logic                         r_insert;
    abif_pkg::t_status            r_pend_st;
    abif_pkg::t_status            n_pend_st;
    logic [abif_pkg::POS_W-1:0]   r_pend_pos;
    logic [abif_pkg::POS_W-1:0]   n_pend_pos;
    logic                         r_out_valid;
    abif_pkg::t_status            r_out_st;
    logic [abif_pkg::POS_W-1:0]   r_out_pos;
    logic                         accept;
    logic                         can_out;
    abif_pkg::t_opcode            op;

    assign op         = abif_pkg::t_opcode'(i_opcode);
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign can_out    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_pend_st  = r_pend_st;
        n_pend_pos = r_pend_pos;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        abif_pkg::OP_INSERT, abif_pkg::OP_FIND: begin
                            if (i_sts.key_ok) begin
                                o_cmd.load = 1'b1;
                                n_state    = S_WALK;
                            end else begin
                                n_pend_st  = abif_pkg::ST_INVALID;
                                n_pend_pos = '0;
                                n_state    = S_RESULT;
                            end
                        end
                        abif_pkg::OP_CLEAR: begin
                            o_cmd.clr_init = 1'b1;
                            n_state        = S_CLEAR;
                        end
                        default: begin
                            n_pend_st  = abif_pkg::ST_INVALID;
                            n_pend_pos = '0;
                            n_state    = S_RESULT;
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_pend_st  = abif_pkg::ST_CLEARED;
                    n_pend_pos = '0;
                    n_state    = r_report ? S_RESULT : S_IDLE;
                end
            end
            S_WALK: begin
                n_state = S_RESULT;
                if (i_sts.empty) begin
                    if (r_insert) begin
                        o_cmd.write = 1'b1;
                        n_pend_st   = abif_pkg::ST_INSERTED;
                        n_pend_pos  = i_sts.pos;
                    end else begin
                        n_pend_st  = abif_pkg::ST_NOT_FOUND;
                        n_pend_pos = '0;
                    end
                end else if (i_sts.match) begin
                    n_pend_st  = r_insert ? abif_pkg::ST_DUPLICATE : abif_pkg::ST_FOUND;
                    n_pend_pos = i_sts.pos;
                end else if (i_sts.past_next) begin
                    n_pend_st  = r_insert ? abif_pkg::ST_NO_SLOT : abif_pkg::ST_NOT_FOUND;
                    n_pend_pos = '0;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_RESULT: begin
                if (can_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_report    <= 1'b0;
            r_insert    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_report <= (op == abif_pkg::OP_CLEAR);
                r_insert <= (op == abif_pkg::OP_INSERT);
            end
            if (r_state == S_RESULT && can_out) begin
                r_out_valid <= 1'b1;
                r_out_st    <= r_pend_st;
                r_out_pos   <= r_pend_pos;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_pend_st  <= n_pend_st;
        r_pend_pos <= n_pend_pos;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_st;
    assign o_position  = r_out_pos;

endmodule

@@ rtl/array_bst_insert_find_top.sv @@
// ----------------------------------------------------------------------------
// array_bst_insert_find_top
// Binary search tree in an implicitly indexed slot array: insert, find, clear.
// ----------------------------------------------------------------------------
// The slave stream carries one operation per transaction: the opcode selects
// insert, find or clear, and the key goes with it. Each transaction returns
// exactly one master-side transaction with a status code and a slot position.
// Insert and find visit one tree level per cycle, since every level needs one
// read of the slot memory and its compare. An operation is accepted, visits
// at most floor(log2(TREE_SLOTS)) + 1 levels, and then loads the result
// register. A clear sweeps the memory one slot per cycle; an invalid key or
// opcode goes straight to the result register. One operation is in flight
// at a time; the next is accepted once the current result is registered.
// After reset the block sweeps the memory to empty and holds s_tready low
// meanwhile. A stalled master side holds its result; the block still accepts
// and works on one more transaction, then waits for the result register to
// free up before presenting that result.
// ----------------------------------------------------------------------------
module array_bst_insert_find_top #(
    parameter int TREE_SLOTS = 15,
    parameter int KEY_BITS   = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // Fields from bit 0 up: opcode (2 bits), key (KEY_BITS bits), zero fill.
    input  logic [((abif_pkg::OP_W + KEY_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // Fields from bit 0 up: status (3 bits), position (4 bits), zero fill.
    output logic [7:0]          o_m_tdata
);

    abif_pkg::t_cmd                  cmd;
    abif_pkg::t_sts                  sts;
    logic [abif_pkg::STS_W-1:0]      status;
    logic [abif_pkg::POS_W-1:0]      position;

    abif_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_opcode    (i_s_tdata[abif_pkg::OP_W-1:0]),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_status    (status),
        .o_position  (position)
    );

    abif_dp #(
        .TREE_SLOTS (TREE_SLOTS),
        .KEY_BITS   (KEY_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_s_tdata[abif_pkg::OP_W +: KEY_BITS]),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

    assign o_m_tdata = {1'b0, position, status};

endmodule
